// File: rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Types and constants shared by the table interpolator modules.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TableDepth   = 1024;
  localparam int ValueColumns = 4;
  localparam int IdxW         = $clog2(TableDepth);
  localparam int CntW         = IdxW + 1;
  localparam int ColW         = 2;
  localparam int QuoW         = 64;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INTERP   = 3'd0,
    ST_SINGLE   = 3'd1,
    ST_NONE     = 3'd2,
    ST_APPENDED = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_RD_LO,
    S_RD_HI,
    S_PREP,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] position;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic [1:0]         column;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } out_word_t;

  // Divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

// File: rtl/tli_divider.sv
// ----------------------------------------------------------------------------
// tli_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tli_divider
  import tli_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  div_ctl_t            ctl,
  input  logic [QuoW-1:0]     dividend,
  input  logic [32:0]         divisor,
  output div_sts_t            sts,
  output logic [QuoW-1:0]     quotient
);

  localparam int StepW = $clog2(QuoW + 1);

  logic [QuoW-1:0]  quo;
  logic [33:0]      rem;
  logic [32:0]      dvs;
  logic [StepW-1:0] steps;
  logic             busy;
  logic             done;
  logic [33:0]      trial;
  logic [33:0]      shifted;

  // Shift in next dividend bit and try a subtract
  always_comb begin
    shifted = {rem[32:0], quo[QuoW-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        steps <= StepW'(QuoW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial;
        quo <= {quo[QuoW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[QuoW-2:0], 1'b0};
      end
    end
  end

  assign sts.done = done;
  assign quotient = quo;

endmodule

// File: rtl/tli_table.sv
// ----------------------------------------------------------------------------
// tli_table
// Sample store: positions and value columns, one write and one read port.
// ----------------------------------------------------------------------------
module tli_table
  import tli_pkg::*;
(
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IdxW-1:0]            wr_addr,
  input  logic signed [31:0]         wr_position,
  input  logic [ValueColumns*32-1:0] wr_values,
  input  logic [IdxW-1:0]            rd_addr,
  output logic signed [31:0]         rd_position,
  output logic [ValueColumns*32-1:0] rd_values
);

  logic [31:0]                pos_mem [TableDepth];
  logic [ValueColumns*32-1:0] val_mem [TableDepth];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_position;
      val_mem[wr_addr] <= wr_values;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_position <= pos_mem[rd_addr];
    rd_values   <= val_mem[rd_addr];
  end

endmodule

// File: rtl/table_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_top
// Sample table with nearest-neighbour search and linear interpolation.
// ----------------------------------------------------------------------------
//  port      | dir | word       | handshake
//  ----------+-----+------------+----------------------------
//  in_word   | in  | in_word_t  | in_valid / in_stall
//  out_word  | out | out_word_t | out_valid / out_stall
//
//  Clear and append, and a query on an empty table, go from acceptance
//  straight to the result word. Any other query first reads the table once
//  per entry over the single RAM port, then runs a bit-serial divide of the
//  64-bit product. One word is in flight at a time; in_stall is high from
//  acceptance until the result word is taken. Reset is synchronous and
//  clears the count and control; table contents stay undefined.
// ----------------------------------------------------------------------------
module table_linear_interpolator_top
  import tli_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  state_t state, state_next;

  logic [CntW-1:0]   count;
  in_word_t          req;
  logic [IdxW-1:0]   rd_addr;
  logic [CntW-1:0]   scan_idx;
  logic [IdxW-1:0]   cmp_idx;
  logic              have_lo, have_hi;
  logic [IdxW-1:0]   lo, hi;
  logic [32:0]       best_lo, best_hi;
  logic signed [31:0] x_lo, x_hi, v_lo, v_hi;
  logic signed [32:0] delta;
  logic [32:0]       mag, num, den;
  logic [QuoW-1:0]   prod;
  logic              neg;
  logic signed [31:0] res_val;
  status_t           res_st;

  logic signed [31:0]         rd_position;
  logic [ValueColumns*32-1:0] rd_values;
  logic                       wr_en;
  logic signed [31:0]         rd_col;
  div_ctl_t                   dctl;
  div_sts_t                   dsts;
  logic [QuoW-1:0]            quo;

  logic              accept;
  logic              cmp_valid;
  logic signed [32:0] d;
  logic [32:0]       ad;
  logic signed [33:0] r_full;

  assign accept = in_valid && !in_stall;
  assign wr_en  = accept && in_word.cmd == CMD_APPEND && count != CntW'(TableDepth);

  tli_table u_table (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (count[IdxW-1:0]),
    .wr_position (in_word.position),
    .wr_values   ({in_word.value_d, in_word.value_c, in_word.value_b, in_word.value_a}),
    .rd_addr     (rd_addr),
    .rd_position (rd_position),
    .rd_values   (rd_values)
  );

  tli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dctl),
    .dividend (prod),
    .divisor  (den),
    .sts      (dsts),
    .quotient (quo)
  );

  // Column select from RAM read data
  always_comb begin
    rd_col = rd_values[req.column*32 +: 32];
  end

  // Read address for scan and operand fetch
  always_comb begin
    rd_addr = scan_idx[IdxW-1:0];
    if (state == S_SCAN_LAST) rd_addr = lo;
    if (state == S_RD_LO) rd_addr = hi;
  end

  // Distance of the entry read last cycle
  always_comb begin
    d  = 33'(req.position) - 33'(rd_position);
    ad = d[32] ? 33'(-d) : 33'(d);
  end

  // Value step between the two neighbours
  always_comb begin
    delta = 33'(v_hi) - 33'(v_lo);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_word.cmd[1] && count != '0) state_next = S_SCAN;
          else state_next = S_OUT;
        end
      end
      S_SCAN:      if (scan_idx == count) state_next = S_SCAN_LAST;
      S_SCAN_LAST: state_next = S_RD_LO;
      S_RD_LO:     state_next = S_RD_HI;
      S_RD_HI:     state_next = S_PREP;
      S_PREP:      state_next = S_MUL;
      S_MUL:       state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (dsts.done) state_next = S_FINISH;
      S_FINISH:    state_next = S_OUT;
      S_OUT:       if (!out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall   = state != S_IDLE;
    out_valid  = state == S_OUT;
    dctl.start = state == S_DIV_START;
    out_word.result_value = res_val;
    out_word.status       = res_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && in_word.cmd == CMD_CLEAR) count <= '0;
      if (wr_en) count <= count + 1'b1;
    end
  end

  assign cmp_valid = state == S_SCAN && scan_idx != '0;
  assign r_full    = neg ? 34'(v_lo) - 34'(quo[32:0]) : 34'(v_lo) + 34'(quo[32:0]);

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= in_word;
      scan_idx <= '0;
      have_lo  <= 1'b0;
      have_hi  <= 1'b0;
      res_val  <= '0;
      case (in_word.cmd)
        CMD_CLEAR:  res_st <= ST_CLEARED;
        CMD_APPEND: res_st <= (count == CntW'(TableDepth)) ? ST_FULL : ST_APPENDED;
        default:    res_st <= ST_NONE;
      endcase
    end
    if (state == S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      cmp_idx  <= scan_idx[IdxW-1:0];
    end
    // Compare one entry per cycle, later entry wins ties
    if (cmp_valid) begin
      if (d <= 0 && (!have_hi || ad <= best_hi)) begin
        have_hi <= 1'b1; best_hi <= ad; hi <= cmp_idx;
      end
      if (d >= 0 && (!have_lo || ad <= best_lo)) begin
        have_lo <= 1'b1; best_lo <= ad; lo <= cmp_idx;
      end
    end
    // lo data arrives in RD_LO, hi data in RD_HI
    if (state == S_RD_LO) begin
      x_lo <= rd_position; v_lo <= rd_col;
    end
    if (state == S_RD_HI) begin
      x_hi <= rd_position; v_hi <= rd_col;
    end
    if (state == S_PREP) begin
      neg   <= delta[32];
      mag   <= delta[32] ? 33'(-delta) : 33'(delta);
      num   <= 33'(req.position) - 33'(x_lo);
      den   <= 33'(x_hi) - 33'(x_lo);
      if (have_lo && have_hi && lo != hi && x_hi > x_lo) begin
        res_st <= ST_INTERP;
      end else begin
        res_st  <= have_lo || have_hi ? ST_SINGLE : ST_NONE;
        res_val <= have_lo ? v_lo : v_hi;
      end
    end
    if (state == S_MUL) prod <= 64'(mag) * 64'(num);
    if (state == S_FINISH && res_st == ST_INTERP) begin
      if (r_full > 34'sd2147483647) res_val <= 32'h7FFFFFFF;
      else if (r_full < -34'sd2147483648) res_val <= 32'h80000000;
      else res_val <= r_full[31:0];
    end
  end

endmodule
